/* design/tld_pkg.sv */
`default_nettype none
package tld_pkg;

  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned NAME_MAX_CHARS = 9;
  localparam int unsigned NAME_W         = CHAR_W * NAME_MAX_CHARS;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned COUNT_W        = 5;

  localparam int unsigned IN_OP_LSB   = 0;
  localparam int unsigned IN_DIR_LSB  = IN_OP_LSB + OP_W;
  localparam int unsigned IN_FILE_LSB = IN_DIR_LSB + NAME_W;
  localparam int unsigned IN_DATA_W   = 128;
  localparam int unsigned OUT_DATA_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_MKDIR  = 2'd0,
    OP_MKFILE = 2'd1,
    OP_DELETE = 2'd2,
    OP_SEARCH = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_NO_DIR     = 3'd1,
    STAT_NO_FILE    = 3'd2,
    STAT_DIRS_FULL  = 3'd3,
    STAT_FILES_FULL = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MKDIR,
    S_DSCAN,
    S_MKFILE,
    S_FSCAN,
    S_DREAD,
    S_DMOVE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic name_we;
    logic cnt_we;
  } dir_ctl_t;

  typedef struct packed {
    logic rd_en;
    logic we;
  } file_ctl_t;

  // keep chars up to the first NUL, at most nchars of them
  function automatic logic [NAME_W-1:0] canon_name(logic [NAME_W-1:0] raw, int nchars);
    logic [NAME_W-1:0] res;
    logic              alive;
    logic [CHAR_W-1:0] ch;
    res   = '0;
    alive = 1'b1;
    for (int c = 0; c < NAME_MAX_CHARS; c++) begin
      ch = raw[NAME_W-1-CHAR_W*c -: CHAR_W];
      if (c >= nchars || ch == '0) alive = 1'b0;
      if (alive) res[NAME_W-1-CHAR_W*c -: CHAR_W] = ch;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* design/tld_dir_store.sv */
`default_nettype none
module tld_dir_store import tld_pkg::*; #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned CNT_W  = 5
) (
  input  wire logic              clk_i,
  input  wire dir_ctl_t          ctl_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [NAME_W-1:0] wr_name_i,
  input  wire logic [CNT_W-1:0]  wr_cnt_i,
  output logic      [NAME_W-1:0] rd_name_o,
  output logic      [CNT_W-1:0]  rd_cnt_o
);

  logic [NAME_W-1:0] name_mem [DEPTH];
  logic [CNT_W-1:0]  cnt_mem  [DEPTH];
  logic [NAME_W-1:0] rd_name_q;
  logic [CNT_W-1:0]  rd_cnt_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.name_we) name_mem[addr_i] <= wr_name_i;
    if (ctl_i.cnt_we)  cnt_mem[addr_i]  <= wr_cnt_i;
    if (ctl_i.rd_en) begin
      rd_name_q <= name_mem[addr_i];
      rd_cnt_q  <= cnt_mem[addr_i];
    end
  end

  assign rd_name_o = rd_name_q;
  assign rd_cnt_o  = rd_cnt_q;

endmodule
`default_nettype wire

/* design/tld_file_store.sv */
`default_nettype none
module tld_file_store import tld_pkg::*; #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8
) (
  input  wire logic              clk_i,
  input  wire file_ctl_t         ctl_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [NAME_W-1:0] wr_data_i,
  output logic      [NAME_W-1:0] rd_data_o
);

  logic [NAME_W-1:0] mem [DEPTH];
  logic [NAME_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we)    mem[addr_i] <= wr_data_i;
    if (ctl_i.rd_en) rd_data_q   <= mem[addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

/* design/two_level_name_directory_core.sv */
// Two-level name directory: a table of directories, each holding a list of file names.
// Input stream (s_axis): one word per command - create directory, create file,
// delete file or search file. Names are nine 7-bit chars, first char on top,
// cut at the first NUL char.
// Output stream (m_axis): one word per command with status and file count.
// Create directory writes the next table entry; the other commands first scan the
// directory names for a match, search and delete then scan its file names, and a
// delete moves the last file of the list into the freed slot. A command holds the
// core until its result is loaded into the output register.
// One command is in work at a time. Each scan reads one name per cycle from a single-port
// synchronous RAM (directory names and counts in one, file names in the other).
// The result sits in an output register, so the next command is accepted
// while the previous result waits for m_axis_tready. When the receiver stalls
// and a second result is ready, the core holds it until the register frees up.
// Reset clears the directory count and all handshake state; the RAMs are not
// cleared, since only written entries are ever read.
`default_nettype none
module two_level_name_directory_core import tld_pkg::*; #(
  parameter int unsigned MAX_DIRS   = 16,
  parameter int unsigned MAX_FILES  = 16,
  parameter int unsigned NAME_CHARS = 9
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // operation, dir_name, file_name
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [OUT_DATA_W-1:0] m_axis_tdata   // status, file_count
);

  localparam int unsigned DAW = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
  localparam int unsigned DCW = $clog2(MAX_DIRS + 1);
  localparam int unsigned CW  = $clog2(MAX_FILES + 1);
  localparam int unsigned PW  = (DCW > CW) ? DCW : CW;
  localparam int unsigned FDEPTH = MAX_DIRS * MAX_FILES;
  localparam int unsigned FAW = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [NAME_W-1:0] dname_q, dname_d, fname_q, fname_d;
  logic [DCW-1:0]    dcnt_q, dcnt_d;
  logic [DAW-1:0]    d_q, d_d;
  logic [FAW-1:0]    base_q, base_d;
  logic [CW-1:0]     n_q, n_d;
  logic [PW-1:0]     ptr_q, ptr_d, cmp_idx_q, cmp_idx_d, k_q, k_d;
  logic              cmp_vld_q, cmp_vld_d;
  status_e           res_st_q, res_st_d, m_st_q, m_st_d;
  logic [COUNT_W-1:0] res_cnt_q, res_cnt_d, m_cnt_q, m_cnt_d;
  logic              m_vld_q, m_vld_d;

  dir_ctl_t          dir_ctl;
  logic [DAW-1:0]    dir_addr;
  logic [NAME_W-1:0] dir_wr_name, dir_rd_name;
  logic [CW-1:0]     dir_wr_cnt, dir_rd_cnt;
  file_ctl_t         file_ctl;
  logic [FAW-1:0]    file_addr;
  logic [NAME_W-1:0] file_wr_data;
  logic [NAME_W-1:0] file_rd_data;

  logic in_acc, out_free, dir_hit, dscan_end, file_hit, fscan_end;
  op_e  in_op;

  assign in_op     = op_e'(s_axis_tdata[IN_OP_LSB +: OP_W]);
  assign in_acc    = s_axis_tvalid && (state_q == S_IDLE);
  assign out_free  = !m_vld_q || m_axis_tready;
  assign dir_hit   = cmp_vld_q && (dir_rd_name == dname_q);
  assign dscan_end = !cmp_vld_q && (ptr_q == PW'(dcnt_q));
  assign file_hit  = cmp_vld_q && (file_rd_data == fname_q);
  assign fscan_end = !cmp_vld_q && (ptr_q == PW'(n_q));

  // file store writes either the new name or the moved word
  assign file_wr_data = (state_q == S_DMOVE) ? file_rd_data : fname_q;

  tld_dir_store #(
    .DEPTH  (MAX_DIRS),
    .ADDR_W (DAW),
    .CNT_W  (CW)
  ) u_dir_store (
    .clk_i     (clk_i),
    .ctl_i     (dir_ctl),
    .addr_i    (dir_addr),
    .wr_name_i (dir_wr_name),
    .wr_cnt_i  (dir_wr_cnt),
    .rd_name_o (dir_rd_name),
    .rd_cnt_o  (dir_rd_cnt)
  );

  tld_file_store #(
    .DEPTH  (FDEPTH),
    .ADDR_W (FAW)
  ) u_file_store (
    .clk_i     (clk_i),
    .ctl_i     (file_ctl),
    .addr_i    (file_addr),
    .wr_data_i (file_wr_data),
    .rd_data_o (file_rd_data)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = (in_op == OP_MKDIR) ? S_MKDIR : S_DSCAN;
      end
      S_MKDIR:  state_d = S_RESP;
      S_DSCAN: begin
        if (dir_hit)        state_d = (op_q == OP_MKFILE) ? S_MKFILE : S_FSCAN;
        else if (dscan_end) state_d = S_RESP;
      end
      S_MKFILE: state_d = S_RESP;
      S_FSCAN: begin
        if (file_hit)       state_d = (op_q == OP_DELETE) ? S_DREAD : S_RESP;
        else if (fscan_end) state_d = S_RESP;
      end
      S_DREAD:  state_d = S_DMOVE;
      S_DMOVE:  state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    op_d        = op_q;
    dname_d     = dname_q;
    fname_d     = fname_q;
    dcnt_d      = dcnt_q;
    d_d         = d_q;
    base_d      = base_q;
    n_d         = n_q;
    ptr_d       = ptr_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = cmp_vld_q;
    k_d         = k_q;
    res_st_d    = res_st_q;
    res_cnt_d   = res_cnt_q;
    m_vld_d     = m_vld_q && !m_axis_tready;
    m_st_d      = m_st_q;
    m_cnt_d     = m_cnt_q;
    dir_ctl     = '0;
    dir_addr    = d_q;
    dir_wr_name = dname_q;
    dir_wr_cnt  = '0;
    file_ctl    = '0;
    file_addr   = base_q + FAW'(ptr_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d      = in_op;
          dname_d   = canon_name(s_axis_tdata[IN_DIR_LSB +: NAME_W], NAME_CHARS);
          fname_d   = canon_name(s_axis_tdata[IN_FILE_LSB +: NAME_W], NAME_CHARS);
          ptr_d     = '0;
          cmp_vld_d = 1'b0;
        end
      end
      S_MKDIR: begin
        res_cnt_d = '0;
        if (dcnt_q == DCW'(MAX_DIRS)) begin
          res_st_d = STAT_DIRS_FULL;
        end else begin
          res_st_d        = STAT_OK;
          dir_ctl.name_we = 1'b1;
          dir_ctl.cnt_we  = 1'b1;
          dir_addr        = dcnt_q[DAW-1:0];
          dcnt_d          = dcnt_q + DCW'(1);
        end
      end
      S_DSCAN: begin
        dir_addr = ptr_q[DAW-1:0];
        if (dir_hit) begin
          d_d       = cmp_idx_q[DAW-1:0];
          n_d       = dir_rd_cnt;
          base_d    = FAW'(32'(cmp_idx_q) * MAX_FILES);
          ptr_d     = '0;
          cmp_vld_d = 1'b0;
        end else if (dscan_end) begin
          res_st_d  = STAT_NO_DIR;
          res_cnt_d = '0;
        end else if (ptr_q != PW'(dcnt_q)) begin
          dir_ctl.rd_en = 1'b1;
          cmp_idx_d     = ptr_q;
          cmp_vld_d     = 1'b1;
          ptr_d         = ptr_q + PW'(1);
        end else begin
          cmp_vld_d = 1'b0;
        end
      end
      S_MKFILE: begin
        if (n_q == CW'(MAX_FILES)) begin
          res_st_d  = STAT_FILES_FULL;
          res_cnt_d = COUNT_W'(n_q);
        end else begin
          file_ctl.we    = 1'b1;
          file_addr      = base_q + FAW'(n_q);
          dir_ctl.cnt_we = 1'b1;
          dir_wr_cnt     = n_q + CW'(1);
          res_st_d       = STAT_OK;
          res_cnt_d      = COUNT_W'(n_q + CW'(1));
        end
      end
      S_FSCAN: begin
        if (file_hit) begin
          k_d       = cmp_idx_q;
          res_st_d  = STAT_OK;
          res_cnt_d = COUNT_W'(n_q);
        end else if (fscan_end) begin
          res_st_d  = STAT_NO_FILE;
          res_cnt_d = COUNT_W'(n_q);
        end else if (ptr_q != PW'(n_q)) begin
          file_ctl.rd_en = 1'b1;
          cmp_idx_d      = ptr_q;
          cmp_vld_d      = 1'b1;
          ptr_d          = ptr_q + PW'(1);
        end else begin
          cmp_vld_d = 1'b0;
        end
      end
      S_DREAD: begin
        file_ctl.rd_en = 1'b1;
        file_addr      = base_q + FAW'(n_q - CW'(1));
      end
      S_DMOVE: begin
        // last file of the list moves into the freed slot
        file_ctl.we    = 1'b1;
        file_addr      = base_q + FAW'(k_q);
        dir_ctl.cnt_we = 1'b1;
        dir_wr_cnt     = n_q - CW'(1);
        res_st_d       = STAT_OK;
        res_cnt_d      = COUNT_W'(n_q - CW'(1));
      end
      S_RESP: begin
        if (out_free) begin
          m_vld_d = 1'b1;
          m_st_d  = res_st_q;
          m_cnt_d = res_cnt_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      dcnt_q    <= '0;
      cmp_vld_q <= 1'b0;
      m_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      dcnt_q    <= dcnt_d;
      cmp_vld_q <= cmp_vld_d;
      m_vld_q   <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    dname_q   <= dname_d;
    fname_q   <= fname_d;
    d_q       <= d_d;
    base_q    <= base_d;
    n_q       <= n_d;
    ptr_q     <= ptr_d;
    cmp_idx_q <= cmp_idx_d;
    k_q       <= k_d;
    res_st_q  <= res_st_d;
    res_cnt_q <= res_cnt_d;
    m_st_q    <= m_st_d;
    m_cnt_q   <= m_cnt_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {m_cnt_q, m_st_q};

  a_dcnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q <= DCW'(MAX_DIRS))
    else $error("directory count above table size");

  a_fscan_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FSCAN) |-> (ptr_q <= PW'(n_q) && n_q <= CW'(MAX_FILES)))
    else $error("file scan ran past list end");

  a_file_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    file_ctl.we |-> (state_q == S_MKFILE || state_q == S_DMOVE))
    else $error("file store written outside create or delete");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != S_IDLE))
    else $error("accepted word did not start work");

  a_resp_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && out_free) |=> m_vld_q)
    else $error("result not loaded into output register");

endmodule
`default_nettype wire
